/* sv/adpcm_block_decoder_top_defines.svh */
// Assertion macros for the ADPCM block decoder.
// Included by adpcm_block_decoder_top; expects clk and rst in scope.
`ifndef ADPCM_BLOCK_DECODER_TOP_DEFINES_SVH
`define ADPCM_BLOCK_DECODER_TOP_DEFINES_SVH

// Checked outside reset.
`define ABD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, during reset as well.
`define ABD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/abd_pkg.sv */
// Shared types, constants and coefficient functions for the ADPCM block decoder.
// No dependencies.
`default_nettype none

package abd_pkg;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_HEADER = 1'b1;

  localparam logic [1:0] QUEUE_DEPTH = 2'd2;
  localparam logic [1:0] LAST_NIBBLE = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [3:0]  shift;
    logic [3:0]  filter;
    logic [15:0] word;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  function automatic logic signed [7:0] coef_newest(input logic [3:0] filter);
    logic signed [7:0] c;
    case (filter)
      4'd1:    c = 8'sd60;
      4'd2:    c = 8'sd115;
      4'd3:    c = 8'sd98;
      4'd4:    c = 8'sd122;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [7:0] coef_older(input logic [3:0] filter);
    logic signed [7:0] c;
    case (filter)
      4'd2:    c = -8'sd52;
      4'd3:    c = -8'sd55;
      4'd4:    c = -8'sd60;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* sv/adpcm_block_decoder_top.sv */
// Top level of the ADPCM block decoder: front-end queue feeding the decode back end.
// Depends on abd_pkg, abd_front, abd_back and adpcm_block_decoder_top_defines.svh.
//
//   Channel | Handshake          | Payload
//   --------+--------------------+----------------------------------
//   input   | in_valid, in_stall | word_in[15:0], is_header
//   output  | out_valid,out_stall| sample[15:0] (signed), last
//
// A data word is fetched from the queue and its four samples are produced, the history
// recurrence setting one sample per cycle while the output register is not stalled.
// A header word only loads the shift and filter; the sequencer stays idle.
// Reset clears the history, shift and filter to zero and empties the queue.
// The two-entry queue takes words during an output stall until both entries are full.
`default_nettype none

`include "adpcm_block_decoder_top_defines.svh"

module adpcm_block_decoder_top (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [15:0]  word_in,
  input  wire logic         is_header,
  input  wire logic         in_valid,
  output logic              in_stall,
  output logic signed [15:0] sample,
  output logic              last,
  output logic              out_valid,
  input  wire logic         out_stall
);

  abd_pkg::queue_head_t head;
  logic                 pop;

  abd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .word_in   (word_in),
    .is_header (is_header),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .head      (head),
    .pop       (pop)
  );

  abd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .sample    (sample),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  `ABD_ASSERT(a_pop_needs_entry, pop |-> head.valid, "Queue popped while empty.")
  `ABD_ASSERT(a_last_spacing, (out_valid && !out_stall && last) |=> !(out_valid && last), "Two final samples delivered too close together.")
  `ABD_ASSERT_ALWAYS(a_reset_clears_output, rst |=> !out_valid, "Output valid after reset.")

endmodule

`default_nettype wire

/* sv/abd_front.sv */
// Front end: accepts block words, classifies them and holds them in a two-entry queue.
// Depends on abd_pkg.
`default_nettype none

module abd_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [15:0]         word_in,
  input  wire logic                is_header,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output abd_pkg::queue_head_t     head,
  input  wire logic                pop
);

  abd_pkg::item_t slots [2];
  abd_pkg::item_t entry;
  logic [1:0]     count;
  logic [1:0]     count_next;
  logic           wr_ptr;
  logic           rd_ptr;
  logic           push;

  assign in_stall = (count == abd_pkg::QUEUE_DEPTH);
  assign push     = in_valid && !in_stall;

  always_comb begin
    entry.kind   = is_header ? abd_pkg::KIND_HEADER : abd_pkg::KIND_DATA;
    entry.shift  = word_in[3:0];
    entry.filter = word_in[7:4];
    entry.word   = is_header ? 16'h0000 : word_in;
  end

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry;
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.item  = slots[rd_ptr];

endmodule

`default_nettype wire

/* sv/abd_back.sv */
// Back end: applies headers and decodes data words into an output register, one sample per cycle unless stalled.
// Depends on abd_pkg.
`default_nettype none

module abd_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire abd_pkg::queue_head_t head,
  output logic                      pop,
  output logic signed [15:0]        sample,
  output logic                      last,
  output logic                      out_valid,
  input  wire logic                 out_stall
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DATA = 1'b1;

  logic                state;
  logic [1:0]          cnt;
  logic [15:0]         word;
  logic [3:0]          shift;
  logic [3:0]          filter;
  logic signed [15:0]  hist_newest;
  logic signed [15:0]  hist_older;

  logic                out_free;
  logic                emit;
  logic [3:0]          nib;
  logic signed [31:0]  placed;
  logic signed [31:0]  shifted;
  logic [4:0]          shift_total;
  logic signed [16:0]  scaled;
  logic signed [7:0]   c1;
  logic signed [7:0]   c2;
  logic signed [23:0]  prod1;
  logic signed [23:0]  prod2;
  logic signed [24:0]  pred_sum;
  logic signed [18:0]  pred;
  logic signed [19:0]  total;
  logic signed [15:0]  sat;

  assign out_free = !out_valid || !out_stall;
  assign pop      = (state == ST_IDLE) && head.valid;
  assign emit     = (state == ST_DATA) && out_free;

  always_comb begin
    nib         = word[{cnt, 2'b00} +: 4];
    placed      = {nib, 28'h0000000};
    shift_total = {1'b0, shift} + 5'd16;
    shifted     = placed >>> shift_total;
    scaled      = shifted[16:0];
    c1          = abd_pkg::coef_newest(filter);
    c2          = abd_pkg::coef_older(filter);
    prod1       = 24'(c1) * 24'(hist_newest);
    prod2       = 24'(c2) * 24'(hist_older);
    pred_sum    = 25'(prod1) + 25'(prod2) + 25'sd32;
    pred        = pred_sum[24:6];
    total       = 20'(scaled) + 20'(pred);
    if (total < -20'sd32768) begin
      sat = -16'sd32768;
    end else if (total > 20'sd32767) begin
      sat = 16'sd32767;
    end else begin
      sat = total[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= 2'd0;
      out_valid   <= 1'b0;
      shift       <= 4'd0;
      filter      <= 4'd0;
      hist_newest <= 16'sd0;
      hist_older  <= 16'sd0;
    end else begin
      if (pop) begin
        if (head.item.kind == abd_pkg::KIND_HEADER) begin
          shift  <= head.item.shift;
          filter <= head.item.filter;
        end else begin
          state <= ST_DATA;
          cnt   <= 2'd0;
        end
      end
      if (emit) begin
        hist_older  <= hist_newest;
        hist_newest <= sat;
        cnt         <= cnt + 2'd1;
        if (cnt == abd_pkg::LAST_NIBBLE) begin
          state <= ST_IDLE;
        end
      end
      if (out_free) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.item.kind == abd_pkg::KIND_DATA) begin
      word <= head.item.word;
    end
    if (emit) begin
      sample <= sat;
      last   <= (cnt == abd_pkg::LAST_NIBBLE);
    end
  end

endmodule

`default_nettype wire
